// ===== hdl/tcpts_pkg.sv =====
// Shared types and constants of the TCP token strip classifier.
package tcpts_pkg;

	localparam logic [2:0] VERDICT_NOT_TCP    = 3'd0;
	localparam logic [2:0] VERDICT_OTHER_PORT = 3'd1;
	localparam logic [2:0] VERDICT_SHORT      = 3'd2;
	localparam logic [2:0] VERDICT_NO_TOKEN   = 3'd3;
	localparam logic [2:0] VERDICT_STRIP      = 3'd4;

	localparam logic [1:0] REG_WATCH_PORT   = 2'd0;
	localparam logic [1:0] REG_TOKEN_WORD   = 2'd1;
	localparam logic [1:0] REG_STRIP_LENGTH = 2'd2;
	localparam logic [1:0] REG_MIN_PAYLOAD  = 2'd3;

	localparam logic [15:0] WATCH_PORT_RST   = 16'd8888;
	localparam logic [31:0] TOKEN_WORD_RST   = 32'h4142_4344;
	localparam logic [7:0]  STRIP_LENGTH_RST = 8'd10;
	localparam logic [7:0]  MIN_PAYLOAD_RST  = 8'd7;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [6:0]  ETH_HDR_BYTES  = 7'd14;
	localparam logic [16:0] MIN_FRAME_LEN  = 17'd34;
	localparam logic [5:0]  MIN_IP_HDR     = 6'd20;

	typedef struct packed {
		logic [15:0] watch_port;
		logic [31:0] token_word;
		logic [7:0]  strip_length;
		logic [7:0]  min_payload;
	} cfg_t;

	// Header fields of one finished frame, handed from capture to verdict.
	typedef struct packed {
		logic [16:0] frame_len;
		logic [15:0] ether_type;
		logic [3:0]  ihl;
		logic [15:0] total_len;
		logic [7:0]  protocol;
		logic [15:0] checksum;
		logic [15:0] dest_port;
		logic [3:0]  data_offset;
		logic [31:0] payload_head;
	} snap_t;

endpackage

// ===== hdl/tcpts_capture.sv =====
// Input register and position-indexed header field capture.
module tcpts_capture import tcpts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        snap_ready,
	output logic        snap_valid,
	output snap_t       snap
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        go_s1;
	logic        free_s2;

	logic [15:0] pos_q;
	logic [15:0] etype_q;
	logic [3:0]  ihl_q;
	logic [15:0] tlen_q;
	logic [7:0]  proto_q;
	logic [15:0] csum_q;
	logic [15:0] dport_q;
	logic [3:0]  doff_q;
	logic [31:0] head_q;

	logic [15:0] pos_n;
	logic [15:0] etype_n;
	logic [3:0]  ihl_n;
	logic [15:0] tlen_n;
	logic [7:0]  proto_n;
	logic [15:0] csum_n;
	logic [15:0] dport_n;
	logic [3:0]  doff_n;
	logic [31:0] head_n;
	logic [6:0]  tcp_start;
	logic [7:0]  pay_start;

	snap_t       snap_s2;
	logic        valid_s2;

	assign free_s2  = !valid_s2 || snap_ready;
	assign go_s1    = valid_s1 && (!last_s1 || free_s2);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// The TCP header starts right after the IP header, so its field places move with the IHL.
	always_comb begin
		etype_n = etype_q;
		ihl_n   = ihl_q;
		tlen_n  = tlen_q;
		proto_n = proto_q;
		csum_n  = csum_q;
		dport_n = dport_q;
		doff_n  = doff_q;
		head_n  = head_q;
		if (pos_q == 16'd12) etype_n[15:8] = byte_s1;
		if (pos_q == 16'd13) etype_n[7:0]  = byte_s1;
		if (pos_q == 16'd14) ihl_n         = byte_s1[3:0];
		if (pos_q == 16'd16) tlen_n[15:8]  = byte_s1;
		if (pos_q == 16'd17) tlen_n[7:0]   = byte_s1;
		if (pos_q == 16'd23) proto_n       = byte_s1;
		if (pos_q == 16'd24) csum_n[15:8]  = byte_s1;
		if (pos_q == 16'd25) csum_n[7:0]   = byte_s1;
		tcp_start = ETH_HDR_BYTES + {1'b0, ihl_n, 2'b00};
		if (pos_q == 16'(tcp_start) + 16'd2)  dport_n[15:8] = byte_s1;
		if (pos_q == 16'(tcp_start) + 16'd3)  dport_n[7:0]  = byte_s1;
		if (pos_q == 16'(tcp_start) + 16'd12) doff_n        = byte_s1[7:4];
		pay_start = 8'(tcp_start) + {2'b00, doff_n, 2'b00};
		for (int k = 0; k < 4; k++) begin
			if (pos_q == 16'(pay_start) + 16'(k)) head_n[(3-k)*8 +: 8] = byte_s1;
		end
		pos_n = (pos_q != 16'hFFFF) ? pos_q + 16'd1 : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			etype_q <= '0;
			ihl_q   <= '0;
			tlen_q  <= '0;
			proto_q <= '0;
			csum_q  <= '0;
			dport_q <= '0;
			doff_q  <= '0;
			head_q  <= '0;
		end else if (go_s1) begin
			if (last_s1) begin
				pos_q   <= '0;
				etype_q <= '0;
				ihl_q   <= '0;
				tlen_q  <= '0;
				proto_q <= '0;
				csum_q  <= '0;
				dport_q <= '0;
				doff_q  <= '0;
				head_q  <= '0;
			end else begin
				pos_q   <= pos_n;
				etype_q <= etype_n;
				ihl_q   <= ihl_n;
				tlen_q  <= tlen_n;
				proto_q <= proto_n;
				csum_q  <= csum_n;
				dport_q <= dport_n;
				doff_q  <= doff_n;
				head_q  <= head_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= go_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			snap_s2.frame_len    <= 17'(pos_q) + 17'd1;
			snap_s2.ether_type   <= etype_n;
			snap_s2.ihl          <= ihl_n;
			snap_s2.total_len    <= tlen_n;
			snap_s2.protocol     <= proto_n;
			snap_s2.checksum     <= csum_n;
			snap_s2.dest_port    <= dport_n;
			snap_s2.data_offset  <= doff_n;
			snap_s2.payload_head <= head_n;
		end
	end

	assign snap_valid = valid_s2;
	assign snap       = snap_s2;

endmodule

// ===== hdl/tcpts_verdict.sv =====
// Verdict, length and incremental checksum update, with the result register.
module tcpts_verdict import tcpts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        snap_valid,
	output logic        snap_ready,
	input  snap_t       snap,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata
);

	logic [5:0]  iph;
	logic [5:0]  tcph;
	logic [7:0]  poff;
	logic [15:0] hdr_sum;
	logic        neg_len;
	logic [15:0] diff_len;
	logic [15:0] plen;
	logic        frame_ok;
	logic        pay_short;
	logic [15:0] strip_tlen;
	logic [17:0] csum_acc;
	logic [16:0] csum_f1;
	logic [15:0] csum_f2;
	logic [2:0]  verdict;
	logic [15:0] ntl;
	logic [15:0] ncs;
	logic [71:0] result;
	logic        valid_s3;
	logic [71:0] data_s3;

	assign snap_ready = !valid_s3 || m_tready;

	always_comb begin
		iph       = {snap.ihl, 2'b00};
		tcph      = {snap.data_offset, 2'b00};
		poff      = 8'(ETH_HDR_BYTES) + 8'(iph) + 8'(tcph);
		hdr_sum   = 16'(iph) + 16'(tcph);
		neg_len   = snap.total_len < hdr_sum;
		diff_len  = snap.total_len - hdr_sum;
		plen      = neg_len ? 16'd0 : diff_len;
		frame_ok  = (snap.frame_len >= MIN_FRAME_LEN) && (snap.ether_type == ETHERTYPE_IPV4)
			&& (snap.protocol == PROTO_TCP) && (iph >= MIN_IP_HDR)
			&& (snap.frame_len >= MIN_FRAME_LEN + 17'(iph));
		// A negative payload length is always too short, and so is a frame that ends
		// before all four payload head bytes arrived.
		pay_short = neg_len || (diff_len < 16'(cfg.min_payload))
			|| (snap.frame_len < 17'(poff) + 17'd4);
		strip_tlen = snap.total_len - 16'(cfg.strip_length);
		csum_acc  = {2'b00, ~snap.checksum} + {2'b00, ~snap.total_len} + {2'b00, strip_tlen};
		csum_f1   = 17'(csum_acc[15:0]) + 17'(csum_acc[17:16]);
		csum_f2   = csum_f1[15:0] + 16'(csum_f1[16]);
		ntl       = snap.total_len;
		ncs       = snap.checksum;
		if (snap.dest_port != cfg.watch_port) begin
			verdict = VERDICT_OTHER_PORT;
		end else if (pay_short) begin
			verdict = VERDICT_SHORT;
		end else if (snap.payload_head != cfg.token_word) begin
			verdict = VERDICT_NO_TOKEN;
		end else begin
			verdict = VERDICT_STRIP;
			ntl     = strip_tlen;
			ncs     = ~csum_f2;
		end
		if (frame_ok) begin
			result = {1'b0, ncs, ntl, plen, poff, tcph, iph, verdict};
		end else begin
			result = {69'd0, VERDICT_NOT_TCP};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (snap_ready) begin
			valid_s3 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			data_s3 <= result;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = data_s3;

endmodule

// ===== hdl/tcp_token_strip_classifier_unit.sv =====
// Top level of the TCP token strip classifier: register port and pipeline.
//
// Frame bytes stream in one per cycle on the slave side, with tlast on the final byte; the
// block sustains one byte every cycle unless a last byte stalls, as below. Header fields are
// picked out by byte position, with the TCP header taken right after the IPv4 header. One
// verdict request leaves on the master side per frame, once the frame's last byte has passed
// the input register and the capture snapshot into the result register. Intermediate bytes
// keep flowing while a verdict waits on the master side; only a further last byte stalls
// behind two unsent verdicts. Registers (byte address): watch_port 0x0, token_word 0x4,
// strip_length 0x8, min_payload 0xC; write them only between frames.
module tcp_token_strip_classifier_unit import tcpts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // frame_byte
	input  logic        s_tlast,  // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// verdict[2:0], ip_header_bytes[8:3], tcp_header_bytes[14:9], payload_offset[22:15],
	// payload_length[38:23], new_total_length[54:39], new_header_checksum[70:55], zero[71]
	output logic [71:0] m_tdata
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;
	logic       snap_valid;
	logic       snap_ready;
	snap_t      snap;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.watch_port   <= WATCH_PORT_RST;
			cfg_q.token_word   <= TOKEN_WORD_RST;
			cfg_q.strip_length <= STRIP_LENGTH_RST;
			cfg_q.min_payload  <= MIN_PAYLOAD_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_WATCH_PORT:   cfg_q.watch_port   <= pwdata[15:0];
				REG_TOKEN_WORD:   cfg_q.token_word   <= pwdata;
				REG_STRIP_LENGTH: cfg_q.strip_length <= pwdata[7:0];
				REG_MIN_PAYLOAD:  cfg_q.min_payload  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WATCH_PORT:   prdata = {16'd0, cfg_q.watch_port};
			REG_TOKEN_WORD:   prdata = cfg_q.token_word;
			REG_STRIP_LENGTH: prdata = {24'd0, cfg_q.strip_length};
			REG_MIN_PAYLOAD:  prdata = {24'd0, cfg_q.min_payload};
			default:          prdata = 32'd0;
		endcase
	end

	tcpts_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.snap_ready (snap_ready),
		.snap_valid (snap_valid),
		.snap       (snap)
	);

	tcpts_verdict u_verdict (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// ===== hdl/tcpts_checker.sv =====
// Port-level checks of the classifier's result stream, bound to the top level.
module tcpts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	// A stalled result request keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Only the five defined verdicts are produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd4)
		else $error("undefined verdict");

	// A rejected frame carries no header information.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == 3'd0 |-> m_tdata[71:3] == 69'd0)
		else $error("rejected frame with nonzero fields");

	// Accepted frames have a full IP header and a consistent payload offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != 3'd0 |->
			m_tdata[8:3] >= 6'd20
			&& m_tdata[22:15] == 8'd14 + 8'(m_tdata[8:3]) + 8'(m_tdata[14:9]))
		else $error("inconsistent header lengths");

endmodule

bind tcp_token_strip_classifier_unit tcpts_checker u_tcpts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for the TCP token strip classifier: frames in, verdicts checked.
module tb;
	import tcpts_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 1000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASES         = 5;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [5:0]  ip_hdr_bytes;
		logic [5:0]  tcp_hdr_bytes;
		logic [7:0]  payload_off;
		logic [15:0] payload_len;
		logic [15:0] total_out;
		logic [15:0] csum_out;
	} verdict_rec_t;

	typedef struct {
		int          n_bytes;
		logic [15:0] ether;
		logic [3:0]  ihl;
		logic [15:0] total;
		logic [7:0]  proto;
		logic [15:0] csum;
		logic [15:0] dport;
		logic [3:0]  doff;
		logic [31:0] head;
	} frame_spec_t;

	typedef struct {
		frame_spec_t  spec;
		bit           typed;
		verdict_rec_t want;
	} script_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tready = 1'b0;
	wire  [31:0] prdata;
	wire         pready;
	wire         s_tready;
	wire         m_tvalid;
	wire  [71:0] m_tdata;

	tcp_token_strip_classifier_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Register copy and header capture of the frame in flight.
	cfg_t        cfg_shadow = '{WATCH_PORT_RST, TOKEN_WORD_RST, STRIP_LENGTH_RST, MIN_PAYLOAD_RST};
	logic [15:0] cap_pos   = '0;
	logic [15:0] cap_ether = '0;
	logic [3:0]  cap_ihl   = '0;
	logic [15:0] cap_total = '0;
	logic [7:0]  cap_proto = '0;
	logic [15:0] cap_csum  = '0;
	logic [15:0] cap_dport = '0;
	logic [3:0]  cap_doff  = '0;
	logic [31:0] cap_head  = '0;

	verdict_rec_t pending_verdicts[$];
	verdict_rec_t typed_by_frame[int];
	script_row_t  script[$];
	logic [7:0]   frame_bytes[$];
	string        field_names[7] = '{"verdict", "ip_header_bytes", "tcp_header_bytes",
		"payload_offset", "payload_length", "new_total_length", "new_header_checksum"};

	int frames_sent   = 0;
	int frames_closed = 0;
	int verdicts_seen = 0;
	int fail_count    = 0;
	int idle_cycles   = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void track_frame_byte(input logic [7:0] b, input logic last);
		int p, ts, ps, len, iph, tcph, poff, plen_s;
		logic [15:0] new_len;
		logic [31:0] sum;
		verdict_rec_t v;
		p = cap_pos;
		if (p == 12) cap_ether[15:8] = b;
		if (p == 13) cap_ether[7:0] = b;
		if (p == 14) cap_ihl = b[3:0];
		if (p == 16) cap_total[15:8] = b;
		if (p == 17) cap_total[7:0] = b;
		if (p == 23) cap_proto = b;
		if (p == 24) cap_csum[15:8] = b;
		if (p == 25) cap_csum[7:0] = b;
		// TCP fields sit right after the IP header as far as it is known by now.
		ts = 14 + 4 * cap_ihl;
		if (p == ts + 2) cap_dport[15:8] = b;
		if (p == ts + 3) cap_dport[7:0] = b;
		if (p == ts + 12) cap_doff = b[7:4];
		ps = ts + 4 * cap_doff;
		for (int k = 0; k < 4; k++)
			if (p == ps + k) cap_head[31 - 8 * k -: 8] = b;
		if (cap_pos != 16'hFFFF) cap_pos = cap_pos + 16'd1;
		if (!last) return;

		len    = p + 1;
		iph    = 4 * cap_ihl;
		tcph   = 4 * cap_doff;
		poff   = 14 + iph + tcph;
		plen_s = int'(cap_total) - iph - tcph;
		v      = '0;
		v.verdict = VERDICT_NOT_TCP;
		if (!(len < int'(MIN_FRAME_LEN) || cap_ether != ETHERTYPE_IPV4 || cap_proto != PROTO_TCP
				|| iph < int'(MIN_IP_HDR) || len < 14 + iph + 20)) begin
			v.ip_hdr_bytes  = 6'(iph);
			v.tcp_hdr_bytes = 6'(tcph);
			v.payload_off   = 8'(poff);
			v.payload_len   = (plen_s < 0) ? 16'd0 : 16'(plen_s);
			v.total_out     = cap_total;
			v.csum_out      = cap_csum;
			if (cap_dport != cfg_shadow.watch_port) begin
				v.verdict = VERDICT_OTHER_PORT;
			end else if (plen_s < int'(cfg_shadow.min_payload) || len < poff + 4) begin
				v.verdict = VERDICT_SHORT;
			end else if (cap_head != cfg_shadow.token_word) begin
				v.verdict = VERDICT_NO_TOKEN;
			end else begin
				// Incremental checksum update for the shorter total length.
				new_len = cap_total - {8'h00, cfg_shadow.strip_length};
				sum = {16'h0, ~cap_csum} + {16'h0, ~cap_total} + {16'h0, new_len};
				sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
				sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
				v.verdict  = VERDICT_STRIP;
				v.total_out = new_len;
				v.csum_out = ~sum[15:0];
			end
		end
		if (typed_by_frame.exists(frames_closed))
			pending_verdicts.push_back(typed_by_frame[frames_closed]);
		else
			pending_verdicts.push_back(v);
		frames_closed++;
		cap_pos   = '0;
		cap_ether = '0;
		cap_ihl   = '0;
		cap_total = '0;
		cap_proto = '0;
		cap_csum  = '0;
		cap_dport = '0;
		cap_doff  = '0;
		cap_head  = '0;
	endfunction

	function automatic logic [15:0] field_value(input verdict_rec_t r, input int k);
		case (k)
			0: return 16'(r.verdict);
			1: return 16'(r.ip_hdr_bytes);
			2: return 16'(r.tcp_hdr_bytes);
			3: return 16'(r.payload_off);
			4: return r.payload_len;
			5: return r.total_out;
			default: return r.csum_out;
		endcase
	endfunction

	function automatic frame_spec_t frame_of(input int n, input logic [15:0] ether,
			input logic [3:0] ihl, input logic [15:0] total, input logic [7:0] proto,
			input logic [15:0] csum, input logic [15:0] dport, input logic [3:0] doff,
			input logic [31:0] head);
		frame_spec_t s;
		s.n_bytes = n;
		s.ether   = ether;
		s.ihl     = ihl;
		s.total   = total;
		s.proto   = proto;
		s.csum    = csum;
		s.dport   = dport;
		s.doff    = doff;
		s.head    = head;
		return s;
	endfunction

	function automatic void add_row(input frame_spec_t s, input bit typed,
			input verdict_rec_t want);
		script_row_t r;
		r.spec  = s;
		r.typed = typed;
		r.want  = want;
		script.push_back(r);
	endfunction

	function automatic void place(input int at, input logic [7:0] v);
		if (at < frame_bytes.size()) frame_bytes[at] = v;
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) track_frame_byte(s_tdata, s_tlast);
	end

	always @(posedge clk) begin : result_check
		verdict_rec_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[2:0], m_tdata[8:3], m_tdata[14:9], m_tdata[22:15],
				m_tdata[38:23], m_tdata[54:39], m_tdata[70:55]};
			verdicts_seen++;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: verdict request with none expected, got %h", $time, got);
				fail_count++;
			end else begin
				want = pending_verdicts.pop_front();
				for (int k = 0; k < 7; k++) begin
					if (field_value(want, k) !== field_value(got, k)) begin
						$display("%0t: %s expected %0h, got %0h", $time, field_names[k],
							field_value(want, k), field_value(got, k));
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Verdict sink: random back-pressure, calm stretches, and now and then a long hold-off.
	initial begin : verdict_sink
		int gap, calm_left, next_hold;
		calm_left = 0;
		next_hold = 10;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (verdicts_seen >= next_hold) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				next_hold += 30;
			end
			if (calm_left > 0) begin
				gap = 0;
				calm_left--;
			end else begin
				gap = $urandom_range(0, 3);
				if ($urandom_range(0, 5) == 0) calm_left = 16;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic last, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_frame(input frame_spec_t s);
		int ts, ps, gap;
		bit calm;
		frame_bytes.delete();
		for (int i = 0; i < s.n_bytes; i++) frame_bytes.push_back(8'($urandom));
		ts = 14 + 4 * s.ihl;
		ps = ts + 4 * s.doff;
		place(12, s.ether[15:8]);
		place(13, s.ether[7:0]);
		place(14, {4'($urandom), s.ihl});
		place(16, s.total[15:8]);
		place(17, s.total[7:0]);
		place(23, s.proto);
		place(24, s.csum[15:8]);
		place(25, s.csum[7:0]);
		place(ts + 2, s.dport[15:8]);
		place(ts + 3, s.dport[7:0]);
		place(ts + 12, {s.doff, 4'($urandom)});
		for (int k = 0; k < 4; k++) place(ps + k, s.head[31 - 8 * k -: 8]);
		calm = ($urandom_range(0, 3) == 0);
		foreach (frame_bytes[i]) begin
			gap = calm ? 0 : $urandom_range(0, 3);
			push_byte(frame_bytes[i], i == frame_bytes.size() - 1, gap);
		end
		frames_sent++;
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_WATCH_PORT:   cfg_shadow.watch_port   = value[15:0];
			REG_TOKEN_WORD:   cfg_shadow.token_word   = value;
			REG_STRIP_LENGTH: cfg_shadow.strip_length = value[7:0];
			default:          cfg_shadow.min_payload  = value[7:0];
		endcase
	endtask

	// Lowers valid and lets the current edge pass, so its predicted verdict is queued.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		frame_spec_t s;
		logic [15:0] ip4, port, cs, port_v;
		logic [7:0]  tcp, strip_v, min_v;
		logic [31:0] tok, token_v;
		int phase_bytes, phase_frames, body, full, roll;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		ip4  = ETHERTYPE_IPV4;
		tcp  = PROTO_TCP;
		port = WATCH_PORT_RST;
		tok  = TOKEN_WORD_RST;
		cs   = 16'hB1E5;
		// Directed frames under the reset register values.
		add_row(frame_of(1, ip4, 5, 52, tcp, cs, port, 5, tok), 1'b1, '0);
		add_row(frame_of(33, ip4, 5, 52, tcp, cs, port, 5, tok), 1'b1, '0);
		add_row(frame_of(66, 16'h86DD, 5, 52, tcp, cs, port, 5, tok), 1'b1, '0);
		add_row(frame_of(66, ip4, 5, 52, 8'd17, cs, port, 5, tok), 1'b1, '0);
		add_row(frame_of(66, 16'hFFFF, 5, 52, 8'hFF, cs, port, 5, tok), 1'b1, '0);
		add_row(frame_of(66, ip4, 4, 52, tcp, cs, port, 5, tok), 1'b1, '0);
		add_row(frame_of(53, ip4, 5, 52, tcp, cs, port, 5, tok), 1'b1, '0);
		add_row(frame_of(66, ip4, 5, 52, tcp, cs, 16'd80, 5, tok), 1'b1,
			'{VERDICT_OTHER_PORT, 6'd20, 6'd20, 8'd54, 16'd12, 16'd52, cs});
		add_row(frame_of(60, ip4, 5, 46, tcp, cs, port, 5, tok), 1'b1,
			'{VERDICT_SHORT, 6'd20, 6'd20, 8'd54, 16'd6, 16'd46, cs});
		add_row(frame_of(66, ip4, 5, 30, tcp, cs, port, 5, tok), 1'b1,
			'{VERDICT_SHORT, 6'd20, 6'd20, 8'd54, 16'd0, 16'd30, cs});
		add_row(frame_of(56, ip4, 5, 52, tcp, cs, port, 5, tok), 1'b1,
			'{VERDICT_SHORT, 6'd20, 6'd20, 8'd54, 16'd12, 16'd52, cs});
		add_row(frame_of(66, ip4, 5, 52, tcp, cs, port, 5, tok ^ 32'h1), 1'b0, '0);
		add_row(frame_of(66, ip4, 5, 52, tcp, cs, port, 5, tok), 1'b0, '0);
		add_row(frame_of(142, ip4, 15, 128, tcp, cs, port, 15, tok), 1'b0, '0);
		add_row(frame_of(66, ip4, 5, 52, tcp, cs, port, 0, tok), 1'b0, '0);
		add_row(frame_of(66, ip4, 5, 52, tcp, cs, port, 1, tok), 1'b0, '0);
		add_row(frame_of(66, ip4, 5, 52, tcp, cs, port, 2, tok), 1'b0, '0);
		add_row(frame_of(66, ip4, 5, 52, tcp, 16'hFFFF, port, 5, tok), 1'b0, '0);
		add_row(frame_of(66, ip4, 5, 16'hFFFF, tcp, 16'h0000, port, 5, tok), 1'b0, '0);

		foreach (script[i]) begin
			if (script[i].typed) typed_by_frame[frames_sent] = script[i].want;
			send_frame(script[i].spec);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			repeat (DRAIN_CYCLES) @(posedge clk);
			case (phase)
				0: begin
					port_v  = WATCH_PORT_RST;
					token_v = TOKEN_WORD_RST;
					strip_v = STRIP_LENGTH_RST;
					min_v   = MIN_PAYLOAD_RST;
				end
				1: begin
					port_v  = '0;
					token_v = '0;
					strip_v = '0;
					min_v   = '0;
				end
				2: begin
					port_v  = '1;
					token_v = '1;
					strip_v = '1;
					min_v   = '1;
				end
				3: begin
					// Largest strip on short frames makes the total length wrap.
					port_v  = 16'($urandom);
					token_v = $urandom;
					strip_v = '1;
					min_v   = '0;
				end
				default: begin
					port_v  = 16'($urandom);
					token_v = $urandom;
					strip_v = 8'($urandom_range(0, 40));
					min_v   = 8'($urandom_range(0, 30));
				end
			endcase
			cfg_write(REG_WATCH_PORT, {16'($urandom), port_v});
			cfg_write(REG_TOKEN_WORD, token_v);
			cfg_write(REG_STRIP_LENGTH, {24'($urandom), strip_v});
			cfg_write(REG_MIN_PAYLOAD, {24'($urandom), min_v});

			phase_bytes  = 0;
			phase_frames = 0;
			while (phase_bytes < 70) begin
				s.ihl  = $urandom_range(0, 1) ? 4'd5 : 4'($urandom_range(5, 15));
				roll   = $urandom_range(0, 19);
				s.doff = (roll == 0) ? 4'($urandom_range(0, 4))
					: (roll < 10) ? 4'd5 : 4'($urandom_range(5, 15));
				body   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
					: $urandom_range(0, 24);
				full   = 14 + 4 * s.ihl + 4 * s.doff + body;
				s.total = 16'(full - 14);
				if ($urandom_range(0, 9) == 0) s.total = 16'($urandom);
				s.n_bytes = full + $urandom_range(0, 4);
				if ($urandom_range(0, 9) == 0) s.n_bytes = $urandom_range(34, full);
				s.ether = ETHERTYPE_IPV4;
				s.proto = PROTO_TCP;
				s.csum  = 16'($urandom);
				s.dport = ($urandom_range(0, 4) != 0) ? cfg_shadow.watch_port : 16'($urandom);
				roll = $urandom_range(0, 4);
				s.head = (roll < 3) ? cfg_shadow.token_word
					: (roll == 3) ? cfg_shadow.token_word ^ (32'h1 << $urandom_range(0, 31))
					: $urandom;
				roll = $urandom_range(0, 99);
				if (roll >= 90) begin
					// Noise: short frames of arbitrary content.
					s.n_bytes = $urandom_range(1, 80);
					s.ether   = 16'($urandom);
					s.proto   = 8'($urandom);
					s.ihl     = 4'($urandom);
					s.doff    = 4'($urandom);
				end else if (roll >= 75) begin
					case ($urandom_range(0, 2))
						0: s.ether = 16'($urandom);
						1: s.proto = 8'($urandom);
						default: s.ihl = 4'($urandom_range(0, 4));
					endcase
				end
				send_frame(s);
				phase_bytes += s.n_bytes;
				phase_frames++;
				if (phase_frames == 6) wait_drained();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
